FILE: src/tcaw_pkg.sv
`default_nettype none
package tcaw_pkg;

  localparam int CELL_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FG_PALETTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR = 1'd1;

  localparam logic [31:0] FG_PALETTE_RESET = 32'hF3D1_E240;
  localparam logic [7:0]  ERROR_ATTR_RESET = 8'h0D;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_G      = 8'h47;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  typedef enum logic [2:0] {
    PH_TEXT,
    PH_ESC,
    PH_BRACKET,
    PH_ZERO,
    PH_SEMI,
    PH_THREE,
    PH_DIGIT
  } phase_t;

  typedef struct packed {
    logic [31:0] fg_palette;
    logic [7:0]  error_attr;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
    logic [7:0] start_col;
    logic [7:0] start_row;
    logic [7:0] base_attr;
  } char_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_address;
    logic [7:0]        cell_char;
    logic [7:0]        cell_attr;
    logic [CELL_W-1:0] cursor_pos;
    logic              last;
  } cell_result_t;

  typedef struct packed {
    logic [1:0]   cnt;
    cell_result_t first;
    cell_result_t second;
  } push_t;

endpackage
`default_nettype wire

FILE: src/tcaw_if.sv
`default_nettype none
interface tcaw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       start_req;
  logic [7:0] start_col;
  logic [7:0] start_row;
  logic [7:0] base_attr;

  modport source (output valid, ch, start_req, start_col, start_row, base_attr,
                  input ready);
  modport sink (input valid, ch, start_req, start_col, start_row, base_attr,
                output ready);
endinterface

interface tcaw_cell_if;
  import tcaw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_address;
  logic [7:0]        cell_char;
  logic [7:0]        cell_attr;
  logic [CELL_W-1:0] cursor_pos;
  logic              last;

  modport source (output valid, cell_address, cell_char, cell_attr, cursor_pos, last,
                  input ready);
  modport sink (input valid, cell_address, cell_char, cell_attr, cursor_pos, last,
                output ready);
endinterface
`default_nettype wire

FILE: src/tcaw_core.sv
`default_nettype none
module tcaw_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  tcaw_pkg::cfg_t cfg,
  input  logic           room,
  tcaw_char_if.sink      char_in,
  output tcaw_pkg::push_t push
);
  import tcaw_pkg::*;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LIN_W = $clog2(COLUMNS * ROWS + 1);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  char_item_t item;
  logic       in_vld;
  logic       fire;

  phase_t           phase;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [7:0]       current_attr;
  logic [7:0]       saved_attr;

  phase_t           phase_next;
  logic [COL_W-1:0] cursor_col_next;
  logic [ROW_W-1:0] cursor_row_next;
  logic [7:0]       current_attr_next;
  logic [7:0]       saved_attr_next;

  phase_t           ph0;
  logic [COL_W-1:0] col0;
  logic [ROW_W-1:0] row0;
  logic [7:0]       cur0;
  logic [COL_W-1:0] col_g;
  logic [ROW_W-1:0] row_g;
  logic             g_cell;
  logic             do_plain;
  logic             plain_put;
  logic [3:0]       pal_nib;
  cell_result_t     g_res;
  cell_result_t     p_res;

  // Start positions are reduced through constant tables built at elaboration.
  logic [COL_W-1:0] col_tab [256];
  logic [ROW_W-1:0] row_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_mod_tab
    assign col_tab[i] = COL_W'(i % COLUMNS);
    assign row_tab[i] = ROW_W'(i % ROWS);
  end

  function automatic logic [ROW_W+COL_W-1:0] advance(input logic [ROW_W-1:0] r,
                                                      input logic [COL_W-1:0] c);
    logic [ROW_W-1:0] nr;
    logic [COL_W-1:0] nc;
    nr = r;
    nc = c + COL_W'(1);
    if (c == COL_LAST) begin
      nc = '0;
      nr = (r == ROW_LAST) ? '0 : r + ROW_W'(1);
    end
    return {nr, nc};
  endfunction

  function automatic cell_result_t make_cell(input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c,
                                             input logic [7:0] chr,
                                             input logic [7:0] attr,
                                             input logic lst);
    cell_result_t res;
    logic [LIN_W-1:0] lin;
    lin              = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
    res.cell_address = CELL_W'(lin);
    res.cell_char    = chr;
    res.cell_attr    = attr;
    res.cursor_pos   = CELL_W'(lin + LIN_W'(1));
    res.last         = lst;
    return res;
  endfunction

  assign fire          = in_vld && room;
  assign char_in.ready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_in.valid && char_in.ready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      item <= '{ch: char_in.ch, start_req: char_in.start_req,
                start_col: char_in.start_col, start_row: char_in.start_row,
                base_attr: char_in.base_attr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TEXT;
      cursor_col   <= '0;
      cursor_row   <= '0;
      current_attr <= '0;
      saved_attr   <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      cursor_col   <= cursor_col_next;
      cursor_row   <= cursor_row_next;
      current_attr <= current_attr_next;
      saved_attr   <= saved_attr_next;
    end
  end

  // A start request replaces the state before the character is looked at.
  assign ph0  = item.start_req ? PH_TEXT : phase;
  assign col0 = item.start_req ? col_tab[item.start_col] : cursor_col;
  assign row0 = item.start_req ? row_tab[item.start_row] : cursor_row;
  assign cur0 = item.start_req ? item.base_attr : current_attr;
  assign saved_attr_next = item.start_req ? item.base_attr : saved_attr;

  assign pal_nib = 4'(cfg.fg_palette >> {item.ch[2:0], 2'b00});

  // Next parse phase and the action the character calls for.
  always_comb begin
    phase_next        = PH_TEXT;
    g_cell            = 1'b0;
    do_plain          = 1'b0;
    current_attr_next = cur0;
    case (ph0)
      PH_TEXT: begin
        do_plain = 1'b1;
      end
      PH_ESC: begin
        if (item.ch == CH_LBRACK) phase_next = PH_BRACKET;
        else do_plain = 1'b1;
      end
      PH_BRACKET: begin
        if (item.ch == CH_ZERO) phase_next = PH_ZERO;
        else do_plain = 1'b1;
      end
      PH_ZERO: begin
        if (item.ch == CH_M) begin
          current_attr_next = saved_attr;
          phase_next        = PH_TEXT;
        end else if (item.ch == CH_SEMI) begin
          phase_next = PH_SEMI;
        end else begin
          do_plain = 1'b1;
        end
      end
      PH_SEMI: begin
        if (item.ch == CH_THREE) phase_next = PH_THREE;
        else do_plain = 1'b1;
      end
      PH_THREE: begin
        if (item.ch inside {[CH_ZERO:CH_SEVEN]}) begin
          current_attr_next = {cur0[7:4], pal_nib};
          phase_next        = PH_DIGIT;
        end else begin
          g_cell = 1'b1;
          if (item.ch == CH_M) phase_next = PH_TEXT;
          else do_plain = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (item.ch == CH_M) phase_next = PH_TEXT;
        else do_plain = 1'b1;
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
    if (do_plain) begin
      phase_next = (item.ch == CH_ESC) ? PH_ESC : PH_TEXT;
    end
  end

  // Cursor movement and the cell writes.
  always_comb begin
    {row_g, col_g} = g_cell ? advance(row0, col0) : {row0, col0};
    plain_put = do_plain && (item.ch != CH_NUL) && (item.ch != CH_NL) &&
                (item.ch != CH_ESC);
    if (do_plain && (item.ch == CH_NL)) begin
      cursor_row_next = (row_g == ROW_LAST) ? '0 : row_g + ROW_W'(1);
      cursor_col_next = '0;
    end else if (plain_put) begin
      {cursor_row_next, cursor_col_next} = advance(row_g, col_g);
    end else begin
      cursor_row_next = row_g;
      cursor_col_next = col_g;
    end
    g_res = make_cell(row0, col0, CH_G, cfg.error_attr, !plain_put);
    p_res = make_cell(row_g, col_g, item.ch, cur0, 1'b1);
    push.cnt    = fire ? (2'({1'b0, g_cell}) + 2'({1'b0, plain_put})) : 2'd0;
    push.first  = g_cell ? g_res : p_res;
    push.second = p_res;
  end

endmodule
`default_nettype wire

FILE: src/tcaw_outq.sv
`default_nettype none
module tcaw_outq (
  input  logic            clk,
  input  logic            rst,
  input  tcaw_pkg::push_t push,
  output logic            room,
  tcaw_cell_if.source     cell_out
);
  import tcaw_pkg::*;

  cell_result_t       mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic [Q_PTR_W:0]   count_next;
  logic               pop;
  cell_result_t       head;

  assign pop  = cell_out.valid && cell_out.ready;
  // Room is judged on the registered fill so that the sink's ready does not
  // reach the input side combinationally.
  assign room = count <= (Q_PTR_W + 1)'(Q_DEPTH - 2);
  assign count_next = count + (Q_PTR_W + 1)'(push.cnt) - (Q_PTR_W + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.cnt);
      rd_ptr <= rd_ptr + Q_PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + Q_PTR_W'(1)] <= push.second;
    end
  end

  assign head                  = mem[rd_ptr];
  assign cell_out.valid        = count != '0;
  assign cell_out.cell_address = head.cell_address;
  assign cell_out.cell_char    = head.cell_char;
  assign cell_out.cell_attr    = head.cell_attr;
  assign cell_out.cursor_pos   = head.cursor_pos;
  assign cell_out.last         = head.last;

endmodule
`default_nettype wire

FILE: src/text_console_ansi_color_writer_unit.sv
// A character accepted on char_in is registered and decoded from that register;
// once the result queue has room, its cell writes enter the queue, from
// which the first is offered on cell_out.
// Throughput: one character per cycle while the queue has room; a character
// that raises an error marker and also prints gives two cell writes, which
// leave one per cycle while cell_out is ready, via a four-entry result queue.
// Reset (synchronous, rst high): parser to plain text, cursor and attributes to
// zero, palette and error attribute to their defaults, queue emptied.
`default_nettype none
module text_console_ansi_color_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tcaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcaw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tcaw_char_if.sink                       char_in,
  tcaw_cell_if.source                     cell_out
);
  import tcaw_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_palette <= FG_PALETTE_RESET;
      cfg.error_attr <= ERROR_ATTR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FG_PALETTE: cfg.fg_palette <= cfg_wdata;
        CFG_ERROR_ATTR: cfg.error_attr <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  tcaw_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .room    (room),
    .char_in (char_in),
    .push    (push)
  );

  tcaw_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .cell_out (cell_out)
  );

endmodule
`default_nettype wire

FILE: src/tcaw_checker.sv
`default_nettype none
module tcaw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] out_address,
  input logic [10:0] out_pos,
  input logic        out_last
);

  // Nothing is offered straight after reset, and the input side is open.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("result offered or input closed after reset");

  a_pos_follows_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pos == 11'(out_address + 11'd1))
    else $error("cursor position is not the cell address plus one");

  // Both writes of one character enter the queue together.
  a_pair_unbroken: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second write of a character is missing");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_address) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind text_console_ansi_color_writer_unit tcaw_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (char_in.ready),
  .out_valid   (cell_out.valid),
  .out_ready   (cell_out.ready),
  .out_address (cell_out.cell_address),
  .out_pos     (cell_out.cursor_pos),
  .out_last    (cell_out.last)
);
`default_nettype wire
